[hdl/htd_pkg.sv]
// Shared constants, codes and types for the Huffman table decoder.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package htd_pkg;

   localparam int TABLE_DEPTH  = 128;
   localparam int MAX_CODE_LEN = 16;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 16;
   localparam int ELEN_W  = 5;
   localparam int EIDX_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 4;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int ACC_W   = MAX_CODE_LEN;
   localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int CMP_W   = (ACC_W > CODE_W) ? ACC_W : CODE_W;
   localparam int LCMP_W  = (LEN_W > ELEN_W) ? LEN_W : ELEN_W;
   localparam int ENTRY_W = SYM_W + CODE_W + ELEN_W;

   localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(BYTE_W);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_SCAN,
      ST_PUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             bad_code;
   } result_type;

endpackage

[hdl/htd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/huffman_table_decoder_unit.sv]
// Huffman table decoder top level: request sequencer, code accumulator and table scan.
// Depends on htd_pkg and htd_ram.
`timescale 1ns / 1ps

// A load request writes one table slot. A data request shifts its valid bits in
// one at a time; after each bit one compare unit walks the table in index order,
// one slot per cycle from the table RAM, and stops at the first valid slot whose
// length and code equal the accumulated code. Each bit passes through a shift
// state (ST_BIT) and the scan (ST_SCAN); a bit that ends a code, or a miss once
// the code has reached MAX_CODE_LEN, queues a result in ST_PUSH, and the request
// closes in ST_FINISH. An output stall can hold ST_PUSH and ST_FINISH. req_stall
// stays high until a data request is done; a load request leaves it low. The
// last result of a request is held back until the request ends so that run_last
// can be marked on it; the request that follows is taken while that result still
// waits in the output register.
module huffman_table_decoder_unit
   import htd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [EIDX_W-1:0]    req_entry_index,
   input  logic [SYM_W-1:0]     req_entry_symbol,
   input  logic [CODE_W-1:0]    req_entry_code,
   input  logic [ELEN_W-1:0]    req_entry_length,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic [CNT_W-1:0]     req_bit_count,
   input  logic                 req_end_of_message,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_bad_code,
   output logic                 rsp_run_last
);

   state_type state_ff, state_in;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ACC_W-1:0]       accum_ff, accum_in;
   logic [LEN_W-1:0]       accum_len_ff, accum_len_in;

   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [CNT_W-1:0]       bits_left_ff, bits_left_in;
   logic                   eom_ff, eom_in;

   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   rd_live_ff, rd_live_in;
   logic                   rd_last_ff, rd_last_in;
   logic                   rd_vbit_ff, rd_vbit_in;

   result_type             res_ff, res_in;
   result_type             pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_res_ff, rsp_res_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   load_req;
   logic                   data_req;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;

   logic [SYM_W-1:0]       rd_symbol;
   logic [CODE_W-1:0]      rd_code;
   logic [ELEN_W-1:0]      rd_length;

   logic                   hit;
   logic                   miss_end;
   logic                   too_long;
   logic                   out_free;

   assign load_req = (state_ff == ST_IDLE) && req_valid && (req_kind == KIND_LOAD);
   assign data_req = (state_ff == ST_IDLE) && req_valid && (req_kind == KIND_DATA);

   // slots beyond the table are dropped
   assign wr_en   = load_req && (int'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr = IDX_W'(req_entry_index);
   assign wr_data = {req_entry_symbol, req_entry_code, req_entry_length};

   htd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign {rd_symbol, rd_code, rd_length} = rd_data;

   // shared compare unit: one slot against the accumulated code
   assign hit = rd_live_ff && rd_vbit_ff
                && (LCMP_W'(rd_length) == LCMP_W'(accum_len_ff))
                && (CMP_W'(rd_code) == CMP_W'(accum_ff));
   assign miss_end = rd_live_ff && rd_last_ff && !hit;
   assign too_long = accum_len_ff >= LEN_W'(MAX_CODE_LEN);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (data_req) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (bits_left_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || (miss_end && too_long)) begin
               state_in = ST_PUSH;
            end else if (miss_end) begin
               state_in = ST_BIT;
            end
         end
         ST_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_BIT;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      valid_in      = valid_ff;
      accum_in      = accum_ff;
      accum_len_in  = accum_len_ff;
      byte_in       = byte_ff;
      bits_left_in  = bits_left_ff;
      eom_in        = eom_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      rd_live_in    = 1'b0;
      rd_last_in    = rd_last_ff;
      rd_vbit_in    = rd_vbit_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (data_req) begin
               byte_in      = req_data_byte;
               bits_left_in = (req_bit_count > BYTE_BITS) ? BYTE_BITS : req_bit_count;
               eom_in       = req_end_of_message;
            end
         end
         ST_BIT: begin
            if (bits_left_ff != '0) begin
               accum_in      = {accum_ff[ACC_W-2:0], byte_ff[BYTE_W-1]};
               accum_len_in  = LEN_W'(accum_len_ff + 1'b1);
               byte_in       = {byte_ff[BYTE_W-2:0], 1'b0};
               bits_left_in  = CNT_W'(bits_left_ff - 1'b1);
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.symbol   = rd_symbol;
               res_in.bad_code = 1'b0;
               accum_in        = '0;
               accum_len_in    = '0;
            end else if (miss_end && too_long) begin
               res_in.symbol   = '0;
               res_in.bad_code = 1'b1;
               accum_in        = '0;
               accum_len_in    = '0;
            end else if (!issue_done_ff) begin
               // advance the read address one slot a cycle
               rd_live_in = 1'b1;
               rd_last_in = (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1));
               rd_vbit_in = valid_ff[scan_idx_ff];
               if (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
               end
            end
         end
         ST_PUSH: begin
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
            end else if (out_free) begin
               rsp_res_in   = pend_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
               pend_in      = res_ff;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_res_in    = pend_ff;
                  rsp_last_in   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
               end
               // drop the partial code at end of message
               if (eom_ff) begin
                  accum_in     = '0;
                  accum_len_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         accum_ff      <= '0;
         accum_len_ff  <= '0;
         rd_live_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         accum_ff      <= accum_in;
         accum_len_ff  <= accum_len_in;
         rd_live_ff    <= rd_live_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      bits_left_ff  <= bits_left_in;
      eom_ff        <= eom_in;
      scan_idx_ff   <= scan_idx_in;
      issue_done_ff <= issue_done_in;
      rd_last_ff    <= rd_last_in;
      rd_vbit_ff    <= rd_vbit_in;
      res_ff        <= res_in;
      pend_ff       <= pend_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_res_ff.symbol;
   assign rsp_bad_code = rsp_res_ff.bad_code;
   assign rsp_run_last = rsp_last_ff;

endmodule
